### rtl/dst_pkg.sv
// ----------------------------------------------------------------------------
// Descriptor slot table package
// Shared field widths, operation and status codes, channel payloads and the
// control state type of the descriptor slot table.
// ----------------------------------------------------------------------------
package dst_pkg;

    localparam int FUNC_W   = 3;
    localparam int SLOT_W   = 6;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 7;

    // Table size; the slot field and the limit register are sized for it.
    localparam int SLOTS    = 64;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd16;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FN_ALLOC      = 3'd0;
    localparam logic [FUNC_W-1:0] FN_CLOSE      = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INSTALL    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_GET_HANDLE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SET_FLAGS  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_GET_FLAGS  = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_INVAL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BADF  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] flag_value;
        logic [WORD_W-1:0] file_handle;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic [WORD_W-1:0]   handle_out;
        logic [WORD_W-1:0]   flags_out;
    } t_rsp;

    typedef struct packed {
        logic [LIMIT_W-1:0] slots_in_use;
    } t_cfg;

    // Decision of the operation unit beyond the response itself.
    typedef struct packed {
        logic               wr_en;
        logic               hint_ld;
        logic [LIMIT_W-1:0] hint_val;
    } t_op_ctl;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_EXEC
    } t_state;

endpackage

### rtl/dst_chan_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel
// One transaction moves the payload when valid and ready are both high at a
// rising clock edge.
// ----------------------------------------------------------------------------
interface dst_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/dst_op.sv
// ----------------------------------------------------------------------------
// Descriptor slot table operation unit
// Decides status, read data, the write-back entry and the hint update of one
// operation from the request and the entry read from the slot memory.
// ----------------------------------------------------------------------------
module dst_op import dst_pkg::*; #(
    parameter int HANDLE_BITS  = 32,
    parameter int RESERVED_BIT = 31
) (
    input  t_req                   i_req,
    input  logic                   i_in_range,
    input  logic                   i_found,
    input  logic [LIMIT_W-1:0]     i_got,
    input  logic [LIMIT_W-1:0]     i_hint,
    input  logic [HANDLE_BITS-1:0] i_handle,
    input  logic [WORD_W-1:0]      i_flags,
    output t_rsp                   o_rsp,
    output t_op_ctl                o_ctl,
    output logic [HANDLE_BITS-1:0] o_wr_handle,
    output logic [WORD_W-1:0]      o_wr_flags
);

    localparam logic [WORD_W-1:0] MARK = WORD_W'(1) << RESERVED_BIT;

    logic [HANDLE_BITS-1:0] new_handle;
    logic                   has_handle;
    logic                   marked;
    logic [LIMIT_W-1:0]     slot_ext;

    assign new_handle = HANDLE_BITS'(i_req.file_handle);
    assign has_handle = (i_handle != '0);
    assign marked     = ((i_flags & MARK) != '0);
    assign slot_ext   = LIMIT_W'(i_req.slot);

    always_comb begin
        o_rsp       = '0;
        o_ctl       = '0;
        o_wr_handle = i_handle;
        o_wr_flags  = i_flags;
        unique case (i_req.func)
            FN_ALLOC: begin
                if (i_found) begin
                    o_ctl.wr_en    = 1'b1;
                    o_ctl.hint_ld  = 1'b1;
                    o_ctl.hint_val = i_got + 1'b1;
                    o_wr_handle    = '0;
                    o_wr_flags     = i_req.flag_value | MARK;
                    o_rsp.slot_out = i_got[SLOT_W-1:0];
                end else begin
                    o_rsp.status = STAT_FULL;
                end
            end
            FN_CLOSE: begin
                if (!i_in_range) begin
                    o_rsp.status = STAT_INVAL;
                end else begin
                    // A held descriptor is wiped; a bare reservation only loses its mark.
                    o_ctl.wr_en = 1'b1;
                    o_wr_handle = '0;
                    o_wr_flags  = has_handle ? '0 : (i_flags & ~MARK);
                    if (has_handle && (slot_ext < i_hint)) begin
                        o_ctl.hint_ld  = 1'b1;
                        o_ctl.hint_val = slot_ext;
                    end
                end
            end
            FN_INSTALL: begin
                if ((new_handle == '0) || !i_in_range) begin
                    o_rsp.status = STAT_INVAL;
                end else if (!marked) begin
                    o_rsp.status = STAT_BADF;
                end else begin
                    o_ctl.wr_en    = 1'b1;
                    o_wr_handle    = new_handle;
                    o_rsp.slot_out = i_req.slot;
                end
            end
            FN_GET_HANDLE: begin
                if (!i_in_range) begin
                    o_rsp.status = STAT_INVAL;
                end else begin
                    o_rsp.handle_out = WORD_W'(i_handle);
                end
            end
            FN_SET_FLAGS: begin
                if (!i_in_range) begin
                    o_rsp.status = STAT_INVAL;
                end else if (!has_handle) begin
                    o_rsp.status = STAT_BADF;
                end else begin
                    o_ctl.wr_en = 1'b1;
                    o_wr_flags  = i_req.flag_value;
                end
            end
            FN_GET_FLAGS: begin
                if (!i_in_range) begin
                    o_rsp.status = STAT_INVAL;
                end else if (has_handle) begin
                    o_rsp.flags_out = i_flags;
                end
            end
            default: begin
                o_rsp.status = STAT_INVAL;
            end
        endcase
    end

endmodule

### rtl/descriptor_slot_table_top.sv
// ----------------------------------------------------------------------------
// Descriptor slot table
// Next-fit descriptor slot allocator with per-slot file handle and flag word,
// kept in one synchronous slot memory.
// ----------------------------------------------------------------------------
// Usage notes.
// Requests arrive on i_req (operation, slot, flag word, file handle) and each
// request transaction produces exactly one response transaction on o_rsp
// (status, slot, handle, flags). The usable-slot limit is written through
// i_cfg, which is always ready; write it only while no request is in flight.
// After reset the block sweeps the slot memory, one entry per cycle;
// i_req is held not ready during that sweep.
// Close, install, get and set operations read the slot memory at the request
// transaction, then apply any write-back and register the response in the
// execute state once the output register is free. Allocate walks the slot
// memory with one read per cycle, first from the hint up to the limit and
// then from slot zero up to the hint, and then executes the same way.
// A new request is taken once the previous one has moved its result into the
// output register. When the receiver stalls, the response is held there and
// the next request may still be accepted, but it cannot finish until the
// held response has been taken.
// ----------------------------------------------------------------------------
module descriptor_slot_table_top import dst_pkg::*; #(
    parameter int HANDLE_BITS  = 32,
    parameter int RESERVED_BIT = 31
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dst_chan_if.sink   i_cfg,
    dst_chan_if.sink   i_req,
    dst_chan_if.source o_rsp
);

    localparam int IW = $clog2(SLOTS);
    localparam int EW = HANDLE_BITS + WORD_W;

    // Slot memory: handle in the upper bits, flag word in the lower bits.
    logic [EW-1:0] mem [SLOTS];
    logic [EW-1:0] r_rd_data;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    t_state             r_state, n_state;
    logic [LIMIT_W-1:0] r_cfg_limit, n_cfg_limit;
    logic [LIMIT_W-1:0] r_hint, n_hint;
    logic [IW-1:0]      r_clr_idx, n_clr_idx;
    logic               r_phase_b, n_phase_b;
    logic               r_chk_valid, n_chk_valid;
    logic               r_found, n_found;
    logic               r_rsp_valid, n_rsp_valid;

    t_req               r_req, n_req;
    logic               r_in_range, n_in_range;
    logic [LIMIT_W-1:0] r_cnt, n_cnt;
    logic [LIMIT_W-1:0] r_end, n_end;
    logic [LIMIT_W-1:0] r_chk_idx, n_chk_idx;
    logic [LIMIT_W-1:0] r_got, n_got;
    t_rsp               r_rsp, n_rsp;

    logic [LIMIT_W-1:0]     limit;
    logic                   req_fire;
    logic                   rsp_free;
    logic [HANDLE_BITS-1:0] ent_handle;
    logic [WORD_W-1:0]      ent_flags;
    logic                   chk_hit;
    logic                   scan_more;

    t_rsp                   op_rsp;
    t_op_ctl                op_ctl;
    logic [HANDLE_BITS-1:0] op_wr_handle;
    logic [WORD_W-1:0]      op_wr_flags;

    // The configured limit is cut to the table size.
    assign limit = (32'(r_cfg_limit) > SLOTS) ? LIMIT_W'(SLOTS) : r_cfg_limit;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

    assign req_fire = i_req.valid && i_req.ready;
    assign rsp_free = !r_rsp_valid || o_rsp.ready;

    assign ent_handle = r_rd_data[EW-1:WORD_W];
    assign ent_flags  = r_rd_data[WORD_W-1:0];

    // A slot is free when it holds no handle and carries no reservation.
    assign chk_hit   = r_chk_valid && (ent_handle == '0) && !ent_flags[RESERVED_BIT];
    assign scan_more = (r_cnt < r_end);

    dst_op #(
        .HANDLE_BITS  (HANDLE_BITS),
        .RESERVED_BIT (RESERVED_BIT)
    ) u_op (
        .i_req       (r_req),
        .i_in_range  (r_in_range),
        .i_found     (r_found),
        .i_got       (r_got),
        .i_hint      (r_hint),
        .i_handle    (ent_handle),
        .i_flags     (ent_flags),
        .o_rsp       (op_rsp),
        .o_ctl       (op_ctl),
        .o_wr_handle (op_wr_handle),
        .o_wr_flags  (op_wr_flags)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == IW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_fire) begin
                    n_state = (i_req.data.func == FN_ALLOC) ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN: begin
                if (chk_hit || (!scan_more && r_phase_b)) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (rsp_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // Memory control and datapath.
    always_comb begin
        n_cfg_limit = i_cfg.valid ? i_cfg.data.slots_in_use : r_cfg_limit;
        n_hint      = r_hint;
        n_clr_idx   = r_clr_idx;
        n_phase_b   = r_phase_b;
        n_chk_valid = 1'b0;
        n_found     = r_found;
        n_rsp_valid = r_rsp_valid && !o_rsp.ready;
        n_req       = r_req;
        n_in_range  = r_in_range;
        n_cnt       = r_cnt;
        n_end       = r_end;
        n_chk_idx   = r_chk_idx;
        n_got       = r_got;
        n_rsp       = r_rsp;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en     = 1'b1;
                wr_addr   = r_clr_idx;
                n_clr_idx = r_clr_idx + 1'b1;
            end
            S_IDLE: begin
                if (req_fire) begin
                    n_req      = i_req.data;
                    n_in_range = (LIMIT_W'(i_req.data.slot) < limit);
                    rd_en      = n_in_range && (i_req.data.func != FN_ALLOC);
                    rd_addr    = IW'(i_req.data.slot);
                    n_cnt      = r_hint;
                    n_end      = limit;
                    n_phase_b  = 1'b0;
                    n_found    = 1'b0;
                end
            end
            S_SCAN: begin
                // One read issued per cycle; its data is checked in the next cycle.
                rd_en       = !chk_hit && scan_more;
                rd_addr     = IW'(r_cnt);
                n_chk_valid = rd_en;
                n_chk_idx   = r_cnt;
                if (rd_en) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (chk_hit) begin
                    n_found = 1'b1;
                    n_got   = r_chk_idx;
                end else if (!scan_more && !r_phase_b) begin
                    // Wrap: the slots below the hint are still unvisited.
                    n_phase_b = 1'b1;
                    n_cnt     = '0;
                    n_end     = (r_hint < limit) ? r_hint : limit;
                end
            end
            S_EXEC: begin
                if (rsp_free) begin
                    wr_en       = op_ctl.wr_en;
                    wr_addr     = (r_req.func == FN_ALLOC) ? IW'(r_got) : IW'(r_req.slot);
                    wr_data     = {op_wr_handle, op_wr_flags};
                    n_rsp_valid = 1'b1;
                    n_rsp       = op_rsp;
                    if (op_ctl.hint_ld) begin
                        n_hint = op_ctl.hint_val;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cfg_limit <= LIMIT_RESET;
            r_hint      <= '0;
            r_clr_idx   <= '0;
            r_phase_b   <= 1'b0;
            r_chk_valid <= 1'b0;
            r_found     <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cfg_limit <= n_cfg_limit;
            r_hint      <= n_hint;
            r_clr_idx   <= n_clr_idx;
            r_phase_b   <= n_phase_b;
            r_chk_valid <= n_chk_valid;
            r_found     <= n_found;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_in_range <= n_in_range;
        r_cnt      <= n_cnt;
        r_end      <= n_end;
        r_chk_idx  <= n_chk_idx;
        r_got      <= n_got;
        r_rsp      <= n_rsp;
    end

    // A taken request always takes the block out of the idle state.
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> (r_state != S_IDLE))
        else $error("request accepted but block returned to idle at once");

    // Reads and writes of the slot memory never share a cycle.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en))
        else $error("slot memory read and write in the same cycle");

    // A granted slot lies below the usable limit.
    a_alloc_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && rsp_free && r_req.func == FN_ALLOC && r_found)
        |-> (r_got < limit))
        else $error("allocated slot beyond the usable limit");

    // Every write lands inside the table.
    a_wr_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (32'(wr_addr) < SLOTS))
        else $error("slot memory write beyond the table");

endmodule

### tb/descriptor_slot_table_top_test.sv
// ----------------------------------------------------------------------------
// Descriptor slot table testbench
// Runs a directed table and then random traffic through the request channel
// across several usable-slot limits. Each response is checked field by field
// against an in-bench model of the slot table or a typed row. Both channel ends
// idle at random, and the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module descriptor_slot_table_top_test;
    import dst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HANDLE_BITS  = 32;
    localparam int RESERVED_BIT = 31;

    // Operation codes the block does not define; both must answer invalid.
    localparam logic [FUNC_W-1:0] FN_UNKNOWN_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNKNOWN_HI = 3'd7;

    localparam logic [WORD_W-1:0] MARK = WORD_W'(1) << RESERVED_BIT;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 125;
    localparam int HOLD_CYCLES = 400;
    // Longest allocate walk at the largest limit, plus some margin.
    localparam int SETTLE_CYCLES = 2 * SLOTS + 20;

    typedef enum logic {
        ROW_OP,
        ROW_LIMIT
    } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        t_req               op;
        logic [LIMIT_W-1:0] limit;
        bit                 fixed;
        t_rsp               rsp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dst_chan_if #(.T(t_cfg)) cfg_if ();
    dst_chan_if #(.T(t_req)) req_if ();
    dst_chan_if #(.T(t_rsp)) rsp_if ();

    descriptor_slot_table_top #(
        .HANDLE_BITS  (HANDLE_BITS),
        .RESERVED_BIT (RESERVED_BIT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Model of the slot table. It is updated once per accepted request
    // transaction, in acceptance order, so the queue of awaited responses
    // lines up with the order in which the block answers.
    // ------------------------------------------------------------------------
    logic [WORD_W-1:0]  model_handle [SLOTS];
    logic [WORD_W-1:0]  model_flags  [SLOTS];
    logic [LIMIT_W-1:0] model_hint;
    logic [LIMIT_W-1:0] model_limit;
    logic [SLOT_W-1:0]  last_granted;

    t_rsp awaited_rsp[$];
    int   mismatches;

    // Set by the request side; steady is read by both sides, want_hold by the response side.
    bit   steady;
    bit   want_hold;

    function automatic int usable_slots();
        return (model_limit > SLOTS) ? SLOTS : int'(model_limit);
    endfunction

    function automatic t_rsp slot_op_outcome(t_req op);
        t_rsp rsp;
        int   lim;
        int   found;
        bit   in_range;
        rsp      = '0;
        lim      = usable_slots();
        in_range = int'(op.slot) < lim;
        case (op.func)
            FN_ALLOC: begin
                // Next fit: from the hint up to the limit, then from slot zero.
                found = -1;
                for (int i = int'(model_hint); i < lim && found < 0; i++) begin
                    if (model_handle[i] == '0 && (model_flags[i] & MARK) == '0) begin
                        found = i;
                    end
                end
                for (int i = 0; i < lim && found < 0; i++) begin
                    if (model_handle[i] == '0 && (model_flags[i] & MARK) == '0) begin
                        found = i;
                    end
                end
                if (found < 0) begin
                    rsp.status = STAT_FULL;
                end else begin
                    model_handle[found] = '0;
                    model_flags[found]  = op.flag_value | MARK;
                    model_hint          = LIMIT_W'(found + 1);
                    rsp.slot_out        = SLOT_W'(found);
                    last_granted        = SLOT_W'(found);
                end
            end
            FN_CLOSE: begin
                if (!in_range) begin
                    rsp.status = STAT_INVAL;
                end else begin
                    if (model_handle[op.slot] != '0) begin
                        model_handle[op.slot] = '0;
                        model_flags[op.slot]  = '0;
                        if (LIMIT_W'(op.slot) < model_hint) begin
                            model_hint = LIMIT_W'(op.slot);
                        end
                    end
                    // The mark goes away even when nothing was installed.
                    model_flags[op.slot] = model_flags[op.slot] & ~MARK;
                end
            end
            FN_INSTALL: begin
                if (op.file_handle == '0 || !in_range) begin
                    rsp.status = STAT_INVAL;
                end else if ((model_flags[op.slot] & MARK) == '0) begin
                    rsp.status = STAT_BADF;
                end else begin
                    model_handle[op.slot] = op.file_handle;
                    rsp.slot_out          = op.slot;
                end
            end
            FN_GET_HANDLE: begin
                if (!in_range) begin
                    rsp.status = STAT_INVAL;
                end else begin
                    rsp.handle_out = model_handle[op.slot];
                end
            end
            FN_SET_FLAGS: begin
                if (!in_range) begin
                    rsp.status = STAT_INVAL;
                end else if (model_handle[op.slot] == '0) begin
                    rsp.status = STAT_BADF;
                end else begin
                    model_flags[op.slot] = op.flag_value;
                end
            end
            FN_GET_FLAGS: begin
                if (!in_range) begin
                    rsp.status = STAT_INVAL;
                end else if (model_handle[op.slot] != '0) begin
                    rsp.flags_out = model_flags[op.slot];
                end
            end
            default: begin
                rsp.status = STAT_INVAL;
            end
        endcase
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table rows.
    // ------------------------------------------------------------------------
    function automatic t_row op_row(logic [FUNC_W-1:0] func, logic [SLOT_W-1:0] slot,
                                    logic [WORD_W-1:0] fval, logic [WORD_W-1:0] fh);
        t_row row;
        row       = '{kind: ROW_OP, op: '0, limit: '0, fixed: 1'b0, rsp: '0};
        row.op    = '{func: func, slot: slot, flag_value: fval, file_handle: fh};
        return row;
    endfunction

    function automatic t_row fixed_row(logic [FUNC_W-1:0] func, logic [SLOT_W-1:0] slot,
                                       logic [WORD_W-1:0] fval, logic [WORD_W-1:0] fh,
                                       logic [STATUS_W-1:0] status,
                                       logic [SLOT_W-1:0] slot_out);
        t_row row;
        row       = op_row(func, slot, fval, fh);
        row.fixed = 1'b1;
        row.rsp   = '{status: status, slot_out: slot_out, handle_out: '0, flags_out: '0};
        return row;
    endfunction

    function automatic t_row limit_row(logic [LIMIT_W-1:0] value);
        t_row row;
        row       = '{kind: ROW_LIMIT, op: '0, limit: value, fixed: 1'b0, rsp: '0};
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Random request generation. Operations are drawn by weight, mostly the
    // allocate, install and close of a descriptor; half of the requests aim
    // at the last granted slot, the rest at arbitrary slots, and some carry
    // zero or all-ones handles or unknown operations.
    // ------------------------------------------------------------------------
    function automatic t_req random_op();
        t_req op;
        int   lim;
        int   pick;
        lim  = usable_slots();
        pick = $urandom_range(99);
        op.flag_value = ($urandom_range(15) == 0) ? '1 : WORD_W'($urandom());
        case ($urandom_range(9))
            0:       op.file_handle = '0;
            1:       op.file_handle = '1;
            default: op.file_handle = WORD_W'($urandom());
        endcase
        if (lim > 0 && $urandom_range(4) != 0) begin
            op.slot = SLOT_W'($urandom_range(lim - 1));
        end else begin
            op.slot = SLOT_W'($urandom_range(SLOTS - 1));
        end
        if ($urandom_range(1) == 0) begin
            op.slot = last_granted;
        end
        if (pick < 28) begin
            op.func = FN_ALLOC;
        end else if (pick < 48) begin
            op.func = FN_INSTALL;
        end else if (pick < 62) begin
            op.func = FN_CLOSE;
        end else if (pick < 72) begin
            op.func = FN_GET_HANDLE;
        end else if (pick < 82) begin
            op.func = FN_SET_FLAGS;
        end else if (pick < 94) begin
            op.func = FN_GET_FLAGS;
        end else if (pick < 97) begin
            op.func = FN_UNKNOWN_LO;
        end else begin
            op.func = FN_UNKNOWN_HI;
        end
        return op;
    endfunction

    // ------------------------------------------------------------------------
    // Request side.
    // ------------------------------------------------------------------------
    task automatic issue_op(input t_req op, input bit fixed, input t_rsp fixed_rsp);
        t_rsp predicted;
        req_if.valid <= 1'b1;
        req_if.data  <= op;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        // The model always advances; a typed row only replaces what is awaited.
        predicted = slot_op_outcome(op);
        awaited_rsp.push_back(fixed ? fixed_rsp : predicted);
    endtask

    task automatic pause_sender();
        if (!steady && $urandom_range(99) < 31) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // The limit is only rewritten once every awaited response has come back.
    // Every request yields a response, so the block is idle by then.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        req_if.valid <= 1'b0;
        while (awaited_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= t_cfg'(value);
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        model_limit = value;
    endtask

    initial begin
        t_row                directed[$];
        logic [LIMIT_W-1:0]  phase_limit [PHASES];

        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;

        for (int i = 0; i < SLOTS; i++) begin
            model_handle[i] = '0;
            model_flags[i]  = '0;
        end
        model_hint   = '0;
        model_limit  = LIMIT_RESET;
        last_granted = '0;
        mismatches   = 0;
        steady       = 1'b0;
        want_hold    = 1'b0;

        // Fresh table at the reset limit of 16.
        directed.push_back(fixed_row(FN_GET_HANDLE, 6'd0, '0, '0, STAT_OK, 6'd0));
        directed.push_back(fixed_row(FN_GET_FLAGS, 6'd15, '1, '1, STAT_OK, 6'd0));
        directed.push_back(fixed_row(FN_GET_HANDLE, 6'd16, '0, '0, STAT_INVAL, 6'd0));
        directed.push_back(fixed_row(FN_CLOSE, 6'd63, '0, '0, STAT_INVAL, 6'd0));
        directed.push_back(fixed_row(FN_UNKNOWN_LO, 6'd0, '0, '0, STAT_INVAL, 6'd0));
        directed.push_back(fixed_row(FN_UNKNOWN_HI, 6'd63, '1, '1, STAT_INVAL, 6'd0));
        // Install needs a reserved slot and a nonzero handle.
        directed.push_back(fixed_row(FN_INSTALL, 6'd0, '0, 32'd5, STAT_BADF, 6'd0));
        directed.push_back(fixed_row(FN_INSTALL, 6'd0, '0, '0, STAT_INVAL, 6'd0));
        directed.push_back(fixed_row(FN_SET_FLAGS, 6'd3, '1, '0, STAT_BADF, 6'd0));
        directed.push_back(fixed_row(FN_ALLOC, 6'd0, '0, '0, STAT_OK, 6'd0));
        directed.push_back(fixed_row(FN_ALLOC, 6'd63, '1, '0, STAT_OK, 6'd1));
        directed.push_back(fixed_row(FN_INSTALL, 6'd0, '0, '1, STAT_OK, 6'd0));
        directed.push_back(op_row(FN_GET_HANDLE, 6'd0, '0, '0));
        directed.push_back(op_row(FN_GET_FLAGS, 6'd0, '0, '0));
        // Writing zero flags drops the reserved mark.
        directed.push_back(op_row(FN_SET_FLAGS, 6'd0, '0, '0));
        directed.push_back(op_row(FN_GET_FLAGS, 6'd0, '0, '0));
        // Close of a reserved slot with no handle only clears the mark.
        directed.push_back(op_row(FN_CLOSE, 6'd1, '0, '0));
        // Hint now sits at the limit: the scan from zero must decide.
        directed.push_back(limit_row(7'd2));
        directed.push_back(op_row(FN_ALLOC, 6'd0, 32'h1234_5678, '0));
        directed.push_back(fixed_row(FN_ALLOC, 6'd0, '0, '0, STAT_FULL, 6'd0));
        // A zero limit leaves no usable slot at all.
        directed.push_back(limit_row(7'd0));
        directed.push_back(fixed_row(FN_ALLOC, 6'd0, '0, '0, STAT_FULL, 6'd0));
        directed.push_back(fixed_row(FN_GET_FLAGS, 6'd0, '0, '0, STAT_INVAL, 6'd0));
        // A limit above the table size is cut to the table size.
        directed.push_back(limit_row(7'd127));
        directed.push_back(op_row(FN_GET_HANDLE, 6'd63, '0, '0));
        directed.push_back(op_row(FN_CLOSE, 6'd0, '0, '0));
        directed.push_back(op_row(FN_ALLOC, 6'd0, 32'h7FFF_FFFF, '0));

        // Full table, single slot (hint left far above it), zero, above the
        // table size, just above it, tiny, and two random limits.
        phase_limit[0] = 7'd64;
        phase_limit[1] = 7'd1;
        phase_limit[2] = 7'd0;
        phase_limit[3] = 7'd127;
        phase_limit[4] = 7'd65;
        phase_limit[5] = 7'd2;
        phase_limit[6] = LIMIT_W'($urandom_range(3, 63));
        phase_limit[7] = LIMIT_W'($urandom_range(127));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_LIMIT) begin
                write_limit(directed[i].limit);
            end else begin
                issue_op(directed[i].op, directed[i].fixed, directed[i].rsp);
                pause_sender();
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            write_limit(phase_limit[p]);
            // The response side starts its long hold-off with the first
            // random phase, while requests keep coming.
            if (p == 0) begin
                want_hold = 1'b1;
            end
            // One phase runs with no idling on either side.
            steady = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                issue_op(random_op(), 1'b0, '0);
                pause_sender();
            end
            steady = 1'b0;
        end
        req_if.valid <= 1'b0;

        while (awaited_rsp.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && awaited_rsp.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Response side: checks each response transaction against the oldest
    // awaited one and drives ready for the next cycle.
    // ------------------------------------------------------------------------
    initial begin
        t_rsp got;
        t_rsp want;
        int   hold_left;
        bit   hold_done;

        hold_left = 0;
        hold_done = 1'b0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.data;
                if (awaited_rsp.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected response: status %0d slot %0d handle %h flags %h",
                                 got.status, got.slot_out, got.handle_out, got.flags_out);
                    end
                end else begin
                    want = awaited_rsp.pop_front();
                    if (got.status !== want.status || got.slot_out !== want.slot_out ||
                        got.handle_out !== want.handle_out ||
                        got.flags_out !== want.flags_out) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("response mismatch at %0t", $realtime);
                            $display("  expected status %0d slot %0d handle %h flags %h",
                                     want.status, want.slot_out, want.handle_out,
                                     want.flags_out);
                            $display("  actual   status %0d slot %0d handle %h flags %h",
                                     got.status, got.slot_out, got.handle_out,
                                     got.flags_out);
                        end
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (want_hold && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= steady || ($urandom_range(99) >= 31);
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
